// File: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define PWPB_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition one implies condition two on the same edge
`define PWPB_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// File: sv/pwpb_pkg.sv
package pwpb_pkg;

  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_SCALE = 3'd1;
  localparam logic [2:0] CMD_ROT   = 3'd2;
  localparam logic [2:0] CMD_MOVE  = 3'd3;
  localparam logic [2:0] CMD_BLEND = 3'd4;

  localparam logic [15:0] ONE_W = 16'd32768;
  localparam logic signed [31:0] ONE_Q = 32'sd65536;
  localparam logic signed [31:0] ACC_MAX = 32'sd2147483647;

  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd49;

  typedef enum logic {
    RD_SQRT,
    RD_DIV
  } rd_mode_t;

  typedef struct packed {
    logic     start;
    rd_mode_t mode;
  } rd_req_t;

endpackage

// File: sv/priority_weighted_pose_blender.sv
// set and load beats produce no result; one beat per cycle while idle
// a blend has an accept step, per source a scan over all SOURCES entries and a pick; for
// a positive weight channel checks, per contributing channel a multiply per component,
// a rotation dot product once one is blended and an apply; then a check, a normalize if
// needed and a finish waiting for a free result register; no beat is taken meanwhile
// synchronous active-low reset clears weights, priorities, valid marks and control
`include "assert_macros.svh"

module priority_weighted_pose_blender #(
  parameter int SOURCES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic [2:0]         in_source,
  input  logic signed [16:0] in_weight,
  input  logic [15:0]        in_priority_req,
  input  logic signed [31:0] in_comp_x,
  input  logic signed [31:0] in_comp_y,
  input  logic signed [31:0] in_comp_z,
  input  logic signed [31:0] in_comp_w,
  input  logic [7:0]         in_port,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_port,
  output logic signed [31:0] out_scale_x,
  output logic signed [31:0] out_scale_y,
  output logic signed [31:0] out_scale_z,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic signed [31:0] out_rot_w,
  output logic signed [31:0] out_move_x,
  output logic signed [31:0] out_move_y,
  output logic signed [31:0] out_move_z,
  output logic [2:0]         out_channels_valid
);

  import pwpb_pkg::*;

  localparam int SW = SOURCES > 1 ? $clog2(SOURCES) : 1;
  localparam int KW = $clog2(SOURCES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_PICK, S_CHAN, S_MUL, S_MACC, S_DOT, S_DACC, S_APPLY,
    S_NCHK, S_SQ, S_SQACC, S_ROOTGO, S_ROOT, S_DIVGO, S_DIV, S_FIN
  } state_t;

  state_t state_r;

  logic signed [16:0] weight_r [SOURCES];
  logic [15:0]        pri_r [SOURCES];
  logic [2:0]         chv_r [SOURCES];
  logic [SOURCES-1:0] visited_r;

  logic [SW-1:0] j_r;
  logic [SW-1:0] best_r;
  logic [15:0]   best_pri_r;
  logic          found_r;
  logic [KW-1:0] k_r;
  logic [16:0]   sw_r;
  logic [2:0]    vmask_r;
  logic [1:0]    ch_r;
  logic [1:0]    cnt_r;
  logic [15:0]   we_r;
  logic [15:0]   used_r [3];
  logic [2:0]    mask_r;
  logic [7:0]    port_r;

  logic signed [31:0] sc_r [3];
  logic signed [31:0] rt_r [4];
  logic signed [31:0] mv_r [3];
  logic signed [31:0] q_r [4];
  logic signed [65:0] dot_r;
  logic [63:0]        n2_r;
  logic [31:0]        len_r;

  logic               out_valid_r;
  logic [7:0]         out_port_r;
  logic signed [31:0] out_sc_r [3];
  logic signed [31:0] out_rt_r [4];
  logic signed [31:0] out_mv_r [3];
  logic [2:0]         out_mask_r;

  logic          accept;
  logic          src_ok;
  logic [4:0]    src5;
  logic [SW-1:0] src_idx;

  logic [95:0]  sc_rd;
  logic [127:0] rt_rd;
  logic [95:0]  mv_rd;

  logic signed [31:0] comp_sel;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] tsum;
  logic signed [31:0] t_val;

  logic [16:0] rem_w;
  logic [15:0] we_calc;
  logic        cand;
  logic [1:0]  last_cnt;
  logic        k_last;
  logic        k_done;

  rd_req_t     rd_req;
  logic        rd_done;
  logic [48:0] rd_res;
  logic [31:0] abs_rt;
  logic [48:0] num_in;
  logic [32:0] den_in;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'(ACC_MAX)) begin
      return ACC_MAX;
    end else if (v < -34'(ACC_MAX)) begin
      return -ACC_MAX;
    end
    return v[31:0];
  endfunction

  assign accept  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign src5    = {2'b00, in_source};
  assign src_idx = src5[SW-1:0];
  assign src_ok  = 32'(in_source) < SOURCES;

  pwpb_ram #(.WIDTH(96), .DEPTH(SOURCES)) u_scale_ram (
    .clk   (clk),
    .we    (accept && src_ok && in_cmd == CMD_SCALE),
    .waddr (src_idx),
    .wdata ({in_comp_z, in_comp_y, in_comp_x}),
    .raddr (best_r),
    .rdata (sc_rd)
  );

  pwpb_ram #(.WIDTH(128), .DEPTH(SOURCES)) u_rot_ram (
    .clk   (clk),
    .we    (accept && src_ok && in_cmd == CMD_ROT),
    .waddr (src_idx),
    .wdata ({in_comp_w, in_comp_z, in_comp_y, in_comp_x}),
    .raddr (best_r),
    .rdata (rt_rd)
  );

  pwpb_ram #(.WIDTH(96), .DEPTH(SOURCES)) u_move_ram (
    .clk   (clk),
    .we    (accept && src_ok && in_cmd == CMD_MOVE),
    .waddr (src_idx),
    .wdata ({in_comp_z, in_comp_y, in_comp_x}),
    .raddr (best_r),
    .rdata (mv_rd)
  );

  pwpb_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pwpb_root_div u_root_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (rd_req),
    .sq_in  (n2_r),
    .num_in (num_in),
    .den_in (den_in),
    .done   (rd_done),
    .res    (rd_res)
  );

  always_comb begin
    case (ch_r)
      2'd0:    comp_sel = sc_rd[32*cnt_r +: 32];
      2'd1:    comp_sel = rt_rd[32*cnt_r +: 32];
      default: comp_sel = mv_rd[32*cnt_r +: 32];
    endcase
    case (state_r)
      S_MUL: begin
        mul_a = comp_sel;
        mul_b = 32'(we_r);
      end
      S_DOT: begin
        mul_a = q_r[cnt_r];
        mul_b = rt_r[cnt_r];
      end
      S_SQ: begin
        mul_a = rt_r[cnt_r];
        mul_b = rt_r[cnt_r];
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  // round half up then drop fifteen fraction bits
  assign tsum  = prod + 64'sd16384;
  assign t_val = tsum[46:15];

  assign rem_w    = 17'(ONE_W) - 17'(used_r[ch_r]);
  assign we_calc  = (sw_r < rem_w) ? sw_r[15:0] : rem_w[15:0];
  assign cand     = !visited_r[j_r] && (!found_r || pri_r[j_r] > best_pri_r);
  assign last_cnt = (ch_r == 2'd1) ? 2'd3 : 2'd2;
  assign k_last   = (k_r == KW'(SOURCES - 1));
  assign k_done   = (k_r == KW'(SOURCES));

  assign rd_req.start = (state_r == S_ROOTGO) || (state_r == S_DIVGO);
  assign rd_req.mode  = (state_r == S_ROOTGO) ? RD_SQRT : RD_DIV;
  assign abs_rt = rt_r[cnt_r][31] ? -rt_r[cnt_r] : rt_r[cnt_r];
  assign num_in = {1'b0, abs_rt[30:0], 17'd0} + 49'(len_r);
  assign den_in = {len_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SOURCES; i++) begin
        weight_r[i] <= 17'sd0;
        pri_r[i]    <= 16'd0;
        chv_r[i]    <= 3'd0;
      end
      for (int i = 0; i < 3; i++) begin
        used_r[i] <= 16'd0;
      end
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_cmd == CMD_BLEND) begin
              port_r    <= in_port;
              mask_r    <= 3'd0;
              visited_r <= '0;
              k_r       <= '0;
              j_r       <= '0;
              found_r   <= 1'b0;
              for (int i = 0; i < 3; i++) begin
                used_r[i] <= 16'd0;
                sc_r[i]   <= ONE_Q;
                mv_r[i]   <= 32'sd0;
              end
              rt_r[0] <= 32'sd0;
              rt_r[1] <= 32'sd0;
              rt_r[2] <= 32'sd0;
              rt_r[3] <= ONE_Q;
              state_r <= S_SCAN;
            end else if (src_ok) begin
              case (in_cmd)
                CMD_SET: begin
                  weight_r[src_idx] <= in_weight;
                  pri_r[src_idx]    <= in_priority_req;
                end
                CMD_SCALE: chv_r[src_idx][0] <= 1'b1;
                CMD_ROT:   chv_r[src_idx][1] <= 1'b1;
                CMD_MOVE:  chv_r[src_idx][2] <= 1'b1;
                default: ;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (cand) begin
            best_r     <= j_r;
            best_pri_r <= pri_r[j_r];
            found_r    <= 1'b1;
          end
          if (j_r == SW'(SOURCES - 1)) begin
            state_r <= S_PICK;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_PICK: begin
          visited_r[best_r] <= 1'b1;
          k_r     <= k_r + 1'b1;
          j_r     <= '0;
          found_r <= 1'b0;
          sw_r    <= weight_r[best_r];
          vmask_r <= chv_r[best_r];
          ch_r    <= 2'd0;
          if (weight_r[best_r][16] || weight_r[best_r] == 17'sd0) begin
            state_r <= k_last ? S_NCHK : S_SCAN;
          end else begin
            state_r <= S_CHAN;
          end
        end
        S_CHAN: begin
          if (vmask_r[ch_r] && used_r[ch_r] < ONE_W) begin
            we_r    <= we_calc;
            cnt_r   <= 2'd0;
            state_r <= S_MUL;
          end else if (ch_r == 2'd2) begin
            state_r <= k_done ? S_NCHK : S_SCAN;
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end
        S_MUL: begin
          state_r <= S_MACC;
        end
        S_MACC: begin
          q_r[cnt_r] <= t_val;
          if (cnt_r == last_cnt) begin
            cnt_r <= 2'd0;
            dot_r <= 66'sd0;
            state_r <= (ch_r == 2'd1 && mask_r[1]) ? S_DOT : S_APPLY;
          end else begin
            cnt_r   <= cnt_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_DOT: begin
          state_r <= S_DACC;
        end
        S_DACC: begin
          dot_r <= dot_r + 66'(prod);
          if (cnt_r == 2'd3) begin
            state_r <= S_APPLY;
          end else begin
            cnt_r   <= cnt_r + 2'd1;
            state_r <= S_DOT;
          end
        end
        S_APPLY: begin
          case (ch_r)
            2'd0: begin
              for (int i = 0; i < 3; i++) begin
                sc_r[i] <= mask_r[0] ? sat(34'(sc_r[i]) + 34'(q_r[i])) : sat(34'(q_r[i]));
              end
            end
            2'd1: begin
              for (int i = 0; i < 4; i++) begin
                if (!mask_r[1]) begin
                  rt_r[i] <= sat(34'(q_r[i]));
                end else if (dot_r[65]) begin
                  rt_r[i] <= sat(34'(rt_r[i]) - 34'(q_r[i]));
                end else begin
                  rt_r[i] <= sat(34'(rt_r[i]) + 34'(q_r[i]));
                end
              end
            end
            default: begin
              for (int i = 0; i < 3; i++) begin
                mv_r[i] <= sat(34'(mv_r[i]) + 34'(q_r[i]));
              end
            end
          endcase
          mask_r[ch_r] <= 1'b1;
          used_r[ch_r] <= used_r[ch_r] + we_r;
          if (ch_r == 2'd2) begin
            state_r <= k_done ? S_NCHK : S_SCAN;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_CHAN;
          end
        end
        S_NCHK: begin
          cnt_r <= 2'd0;
          n2_r  <= 64'd0;
          state_r <= (mask_r[1] && used_r[1] < ONE_W) ? S_SQ : S_FIN;
        end
        S_SQ: begin
          state_r <= S_SQACC;
        end
        S_SQACC: begin
          n2_r <= n2_r + prod;
          if (cnt_r == 2'd3) begin
            state_r <= S_ROOTGO;
          end else begin
            cnt_r   <= cnt_r + 2'd1;
            state_r <= S_SQ;
          end
        end
        S_ROOTGO: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (rd_done) begin
            len_r <= rd_res[31:0];
            cnt_r <= 2'd0;
            if (rd_res[31:0] == 32'd0) begin
              rt_r[0] <= 32'sd0;
              rt_r[1] <= 32'sd0;
              rt_r[2] <= 32'sd0;
              rt_r[3] <= ONE_Q;
              state_r <= S_FIN;
            end else begin
              state_r <= S_DIVGO;
            end
          end
        end
        S_DIVGO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (rd_done) begin
            rt_r[cnt_r] <= rt_r[cnt_r][31] ? -$signed(rd_res[31:0]) : $signed(rd_res[31:0]);
            if (cnt_r == 2'd3) begin
              state_r <= S_FIN;
            end else begin
              cnt_r   <= cnt_r + 2'd1;
              state_r <= S_DIVGO;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_port_r  <= port_r;
            out_mask_r  <= mask_r;
            for (int i = 0; i < 3; i++) begin
              out_sc_r[i] <= sc_r[i];
              out_mv_r[i] <= mv_r[i];
            end
            for (int i = 0; i < 4; i++) begin
              out_rt_r[i] <= rt_r[i];
            end
            for (int i = 0; i < SOURCES; i++) begin
              chv_r[i] <= 3'd0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_port           = out_port_r;
  assign out_scale_x        = out_sc_r[0];
  assign out_scale_y        = out_sc_r[1];
  assign out_scale_z        = out_sc_r[2];
  assign out_rot_x          = out_rt_r[0];
  assign out_rot_y          = out_rt_r[1];
  assign out_rot_z          = out_rt_r[2];
  assign out_rot_w          = out_rt_r[3];
  assign out_move_x         = out_mv_r[0];
  assign out_move_y         = out_mv_r[1];
  assign out_move_z         = out_mv_r[2];
  assign out_channels_valid = out_mask_r;

  `PWPB_ASSERT(a_out_from_fin, !$rose(out_valid) || $past(state_r == S_FIN), "result beat without finish")
  `PWPB_ASSERT(a_used_cap, used_r[0] <= ONE_W && used_r[1] <= ONE_W && used_r[2] <= ONE_W, "weight overflow")
  `PWPB_ASSERT_IMP(a_rd_done_state, rd_done, state_r == S_ROOT || state_r == S_DIV, "stray root/div done")

endmodule

// File: sv/pwpb_ram.sv
module pwpb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: sv/pwpb_mul.sv
module pwpb_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// File: sv/pwpb_root_div.sv
module pwpb_root_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pwpb_pkg::rd_req_t req,
  input  logic [63:0]       sq_in,
  input  logic [48:0]       num_in,
  input  logic [32:0]       den_in,
  output logic              done,
  output logic [48:0]       res
);

  import pwpb_pkg::*;

  logic     busy_r;
  logic     done_r;
  rd_mode_t mode_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;

  logic [63:0] a_op;
  logic [63:0] b_op;
  logic [64:0] diff;
  logic        ge;

  // one shared trial subtract for both root and quotient digits
  always_comb begin
    if (mode_r == RD_SQRT) begin
      a_op = acc_r;
      b_op = res_r + bit_r;
    end else begin
      a_op = {acc_r[62:0], res_r[48]};
      b_op = bit_r;
    end
    diff = {1'b0, a_op} - {1'b0, b_op};
    ge   = !diff[64];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= RD_SQRT;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        mode_r <= req.mode;
        if (req.mode == RD_SQRT) begin
          cnt_r <= SQRT_STEPS;
          acc_r <= sq_in;
          res_r <= 64'd0;
          bit_r <= 64'd1 << 62;
        end else begin
          cnt_r <= DIV_STEPS;
          acc_r <= 64'd0;
          res_r <= {15'd0, num_in};
          bit_r <= {31'd0, den_in};
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        if (mode_r == RD_SQRT) begin
          acc_r <= ge ? diff[63:0] : acc_r;
          res_r <= (res_r >> 1) + (ge ? bit_r : 64'd0);
          bit_r <= bit_r >> 2;
        end else begin
          acc_r <= ge ? diff[63:0] : a_op;
          res_r <= {res_r[62:0], ge};
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r[48:0];

endmodule
